// ===== design/ptwa_pkg.sv =====
// Shared types and constants for the peer table with aging.
`default_nettype none

package ptwa_pkg;

  localparam int unsigned TABLE_ENTRIES = 16;
  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;

  localparam int unsigned FUNC_W = 2;
  localparam int unsigned MAC_W = 48;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned INTERVAL_W = 31;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned SLOT_W = 4;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(60000);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_PRUNE  = 2'd2,
    FUNC_FIND   = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_NO_FREE   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_COMMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic commit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== design/ptwa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ptwa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                          wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== design/ptwa_ctrl.sv =====
// Controller state machine: sequences capture, table scan and commit.
`default_nettype none

module ptwa_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_stall_o,
  input  wire ptwa_pkg::stat_t stat_i,
  output ptwa_pkg::cmd_t      cmd_o
);
  import ptwa_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_SCAN;
      end
      S_SCAN: begin
        if (stat_i.scan_done) state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.capture = in_valid_i;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
      end
      S_COMMIT: begin
        cmd_o.commit = stat_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/ptwa_datapath.sv =====
// Datapath: table storage, scan compare, commit writes and output register.
`default_nettype none

module ptwa_datapath (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ptwa_pkg::cmd_t                      cmd_i,
  output ptwa_pkg::stat_t                          stat_o,
  input  wire logic [ptwa_pkg::FUNC_W-1:0]         func_i,
  input  wire logic [ptwa_pkg::MAC_W-1:0]          mac_address_i,
  input  wire logic [ptwa_pkg::TIME_W-1:0]         now_ms_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [ptwa_pkg::INTERVAL_W-1:0]     cfg_data_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [ptwa_pkg::STATUS_W-1:0]       status_o,
  output logic                                     hit_o,
  output logic      [ptwa_pkg::SLOT_W-1:0]         slot_o,
  output logic      [ptwa_pkg::TIME_W-1:0]         last_seen_ms_o
);
  import ptwa_pkg::*;

  // Captured transaction.
  func_e             func_q;
  logic [MAC_W-1:0]  mac_q;
  logic [TIME_W-1:0] now_q;

  logic [INTERVAL_W-1:0] interval_q;
  logic [TABLE_ENTRIES-1:0] valid_q;

  // Scan pipeline: read address counter and the index whose data is on the RAM outputs.
  logic [CNT_W-1:0] rd_cnt_q;
  logic             cmp_vld_q;
  logic [IDX_W-1:0] cmp_idx_q;

  logic             match_found_q;
  logic [IDX_W-1:0] match_idx_q;
  logic [TIME_W-1:0] match_seen_q;
  logic             free_found_q;
  logic [IDX_W-1:0] free_idx_q;

  logic [MAC_W-1:0]  mac_rdata;
  logic [TIME_W-1:0] seen_rdata;

  logic              out_valid_q;
  logic [STATUS_W-1:0] status_q;
  logic              hit_q;
  logic [SLOT_W-1:0] slot_q;
  logic [TIME_W-1:0] last_seen_q;

  logic             cmp_entry_valid;
  logic             cmp_match;
  logic [TIME_W-1:0] cmp_age;
  logic             cmp_expired;
  logic             rd_more;

  logic             mac_we;
  logic             seen_we;
  logic [IDX_W-1:0] wr_idx;

  logic [STATUS_W-1:0] res_status;
  logic                res_hit;
  logic [IDX_W-1:0]    res_idx;
  logic [TIME_W-1:0]   res_seen;
  logic [IDX_W+SLOT_W-1:0] res_idx_ext;

  ptwa_ram #(.WIDTH(MAC_W), .DEPTH(TABLE_ENTRIES)) u_mac_ram (
    .clk_i   (clk_i),
    .we_i    (mac_we),
    .waddr_i (wr_idx),
    .wdata_i (mac_q),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (mac_rdata)
  );

  ptwa_ram #(.WIDTH(TIME_W), .DEPTH(TABLE_ENTRIES)) u_seen_ram (
    .clk_i   (clk_i),
    .we_i    (seen_we),
    .waddr_i (wr_idx),
    .wdata_i (now_q),
    .raddr_i (rd_cnt_q[IDX_W-1:0]),
    .rdata_o (seen_rdata)
  );

  assign rd_more         = rd_cnt_q < CNT_W'(TABLE_ENTRIES);
  assign cmp_entry_valid = valid_q[cmp_idx_q];
  assign cmp_match       = cmp_entry_valid && (mac_rdata == mac_q);
  assign cmp_age         = now_q - seen_rdata;
  assign cmp_expired     = cmp_entry_valid && (cmp_age > {1'b0, interval_q});

  assign stat_o.scan_done = cmp_vld_q && (cmp_idx_q == IDX_W'(TABLE_ENTRIES - 1));
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

  // Commit decisions.
  always_comb begin
    mac_we     = 1'b0;
    seen_we    = 1'b0;
    wr_idx     = match_found_q ? match_idx_q : free_idx_q;
    res_status = ST_OK;
    res_hit    = 1'b0;
    res_idx    = '0;
    res_seen   = '0;
    case (func_q)
      FUNC_ADD: begin
        if (match_found_q) begin
          seen_we = cmd_i.commit;
          res_hit = 1'b1;
          res_idx = match_idx_q;
        end else if (free_found_q) begin
          mac_we  = cmd_i.commit;
          seen_we = cmd_i.commit;
          res_idx = free_idx_q;
        end else begin
          res_status = ST_NO_FREE;
        end
      end
      FUNC_REMOVE: begin
        if (match_found_q) begin
          res_hit = 1'b1;
          res_idx = match_idx_q;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      FUNC_PRUNE: begin
        res_status = ST_OK;
      end
      FUNC_FIND: begin
        if (match_found_q) begin
          res_hit  = 1'b1;
          res_idx  = match_idx_q;
          res_seen = match_seen_q;
        end else begin
          res_status = ST_NOT_FOUND;
        end
      end
      default: res_status = ST_OK;
    endcase
  end

  // Slot reports the index modulo 16.
  assign res_idx_ext = {{SLOT_W{1'b0}}, res_idx};

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= func_e'(func_i);
      mac_q  <= mac_address_i;
      now_q  <= now_ms_i;
    end
    if (cmd_i.commit) begin
      status_q    <= res_status;
      hit_q       <= res_hit;
      slot_q      <= res_idx_ext[SLOT_W-1:0];
      last_seen_q <= res_seen;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q    <= INTERVAL_RESET;
      valid_q       <= '0;
      rd_cnt_q      <= '0;
      cmp_vld_q     <= 1'b0;
      cmp_idx_q     <= '0;
      match_found_q <= 1'b0;
      match_idx_q   <= '0;
      match_seen_q  <= '0;
      free_found_q  <= 1'b0;
      free_idx_q    <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        interval_q <= cfg_data_i;
      end

      if (cmd_i.capture) begin
        rd_cnt_q      <= '0;
        cmp_vld_q     <= 1'b0;
        match_found_q <= 1'b0;
        free_found_q  <= 1'b0;
      end else if (cmd_i.scan_step) begin
        cmp_vld_q <= rd_more;
        if (rd_more) begin
          cmp_idx_q <= rd_cnt_q[IDX_W-1:0];
          rd_cnt_q  <= rd_cnt_q + CNT_W'(1);
        end
      end

      if (cmp_vld_q) begin
        if (cmp_match && !match_found_q) begin
          match_found_q <= 1'b1;
          match_idx_q   <= cmp_idx_q;
          match_seen_q  <= seen_rdata;
        end
        if (!cmp_entry_valid && !free_found_q) begin
          free_found_q <= 1'b1;
          free_idx_q   <= cmp_idx_q;
        end
        if ((func_q == FUNC_PRUNE) && cmp_expired) begin
          valid_q[cmp_idx_q] <= 1'b0;
        end
      end

      if (cmd_i.commit) begin
        if ((func_q == FUNC_ADD) && !match_found_q && free_found_q) begin
          valid_q[free_idx_q] <= 1'b1;
        end
        if ((func_q == FUNC_REMOVE) && match_found_q) begin
          valid_q[match_idx_q] <= 1'b0;
        end
      end

      if (cmd_i.commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign hit_o          = hit_q;
  assign slot_o         = slot_q;
  assign last_seen_ms_o = last_seen_q;

endmodule

`default_nettype wire

// ===== design/peer_table_with_aging_unit.sv =====
// Top level of the peer table with aging: controller plus datapath.
`default_nettype none

// Peer table with aging. The block keeps a table of TABLE_ENTRIES peers keyed by a
// 48-bit MAC address, each with the millisecond time of its last heartbeat. Every
// input transaction carries an operation (add or refresh, remove, prune, find), a MAC
// and the current time, and yields exactly one result transaction. Each operation
// scans the whole table one entry per cycle through the registered read ports of
// the MAC and time memories, and an item occupies the block until its commit: it
// accepts the transaction, scans every entry, waits out the read latency of the
// last entry, then commits the table update and loads the result register. The
// result register decouples the two sides: the next input transaction is taken
// while a finished result still waits, and a commit waits only if the previous
// result has not yet been taken. Valid marks are cleared by reset, so the block
// accepts input right away. The prune interval register resets to 60000 ms and
// may be written whenever no transaction is in flight; an entry whose age, taken
// modulo 2^32, exceeds the interval is freed by prune. Where several valid
// entries match, the lowest index wins; slot reports the index modulo 16.
module peer_table_with_aging_unit (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,

  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [ptwa_pkg::FUNC_W-1:0]         func_i,
  input  wire logic [ptwa_pkg::MAC_W-1:0]          mac_address_i,
  input  wire logic [ptwa_pkg::TIME_W-1:0]         now_ms_i,

  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic      [ptwa_pkg::STATUS_W-1:0]       status_o,
  output logic                                     hit_o,
  output logic      [ptwa_pkg::SLOT_W-1:0]         slot_o,
  output logic      [ptwa_pkg::TIME_W-1:0]         last_seen_ms_o,

  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [ptwa_pkg::INTERVAL_W-1:0]     cfg_data_i
);
  import ptwa_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The interval register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  ptwa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ptwa_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .func_i         (func_i),
    .mac_address_i  (mac_address_i),
    .now_ms_i       (now_ms_i),
    .cfg_we_i       (cfg_valid_i && cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .hit_o          (hit_o),
    .slot_o         (slot_o),
    .last_seen_ms_o (last_seen_ms_o)
  );

endmodule

`default_nettype wire

// ===== test/peer_table_with_aging_unit_tb.sv =====
// Self-checking testbench for the peer table with aging unit.
`timescale 1ns / 100ps

// The testbench keeps its own copy of the peer table and the prune interval. An
// initial block resets the block and fills a queue of pending operations. A clocked
// driver offers them in bursts with random gaps between bursts. Each input
// transaction that is accepted is run through the local table model at once, and the
// predicted answer is queued. A clocked monitor takes every output transaction and
// compares it field by field with the oldest predicted answer. The stall process on
// the output side follows a pattern of its own. A few times it also holds off for
// a long stretch so that the block fills up and stalls its input. The prune
// interval is rewritten between phases, and only once the block has gone idle.
module peer_table_with_aging_unit_tb;
  import ptwa_pkg::*;

  // One operation as it is offered on the input side.
  typedef struct {
    func_e                func;
    logic [MAC_W-1:0]     mac;
    logic [TIME_W-1:0]    now;
  } peer_op_t;

  // One answer as it is expected on the output side.
  typedef struct {
    status_e              status;
    logic                 hit;
    logic [SLOT_W-1:0]    slot;
    logic [TIME_W-1:0]    seen;
  } peer_answer_t;

  localparam int unsigned POOL_SIZE = 20;

  logic                   clk_i;
  logic                   rst_ni = 1'b0;

  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [FUNC_W-1:0]      in_func = '0;
  logic [MAC_W-1:0]       in_mac = '0;
  logic [TIME_W-1:0]      in_now = '0;

  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic                   hit;
  logic [SLOT_W-1:0]      slot;
  logic [TIME_W-1:0]      last_seen;

  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [INTERVAL_W-1:0]  cfg_data = '0;

  // Local copy of the peer table and of the prune interval.
  logic                   tbl_valid [TABLE_ENTRIES];
  logic [MAC_W-1:0]       tbl_mac   [TABLE_ENTRIES];
  logic [TIME_W-1:0]      tbl_seen  [TABLE_ENTRIES];
  logic [INTERVAL_W-1:0]  interval_ms = INTERVAL_RESET;

  peer_op_t               op_q[$];
  peer_answer_t           answer_q[$];
  peer_op_t               cur_op;

  int                     fail_count = 0;
  int                     n_sent = 0;
  int                     burst_left = 0;
  int                     gap_left = 0;

  int                     hold_left = 0;
  int                     next_hold_at = 150;
  int                     pat_left = 0;
  int                     pat_mode = 0;
  logic [7:0]             pat_phase = '0;

  peer_table_with_aging_unit u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .func_i         (in_func),
    .mac_address_i  (in_mac),
    .now_ms_i       (in_now),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .status_o       (status),
    .hit_o          (hit),
    .slot_o         (slot),
    .last_seen_ms_o (last_seen),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_mac[i]   = '0;
      tbl_seen[i]  = '0;
    end
  end

  // Applies one operation to the local table and returns the answer it yields.
  function automatic peer_answer_t run_peer_op(input peer_op_t op);
    peer_answer_t      ans;
    int                match_idx;
    int                free_idx;
    logic [TIME_W-1:0] age;
    ans.status = ST_OK;
    ans.hit    = 1'b0;
    ans.slot   = '0;
    ans.seen   = '0;
    match_idx  = -1;
    free_idx   = -1;
    // Walking downward leaves the lowest matching and the lowest free index.
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (tbl_valid[i] && tbl_mac[i] == op.mac) match_idx = i;
      if (!tbl_valid[i]) free_idx = i;
    end
    case (op.func)
      FUNC_ADD: begin
        if (match_idx >= 0) begin
          tbl_seen[match_idx] = op.now;
          ans.hit  = 1'b1;
          ans.slot = match_idx[SLOT_W-1:0];
        end else if (free_idx >= 0) begin
          tbl_valid[free_idx] = 1'b1;
          tbl_mac[free_idx]   = op.mac;
          tbl_seen[free_idx]  = op.now;
          ans.slot = free_idx[SLOT_W-1:0];
        end else begin
          ans.status = ST_NO_FREE;
        end
      end
      FUNC_REMOVE: begin
        if (match_idx >= 0) begin
          tbl_valid[match_idx] = 1'b0;
          ans.hit  = 1'b1;
          ans.slot = match_idx[SLOT_W-1:0];
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end
      FUNC_PRUNE: begin
        // The age is taken modulo 2^32, so a time behind the heartbeat reads as very old.
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          age = op.now - tbl_seen[i];
          if (tbl_valid[i] && age > {1'b0, interval_ms}) tbl_valid[i] = 1'b0;
        end
      end
      default: begin
        if (match_idx >= 0) begin
          ans.hit  = 1'b1;
          ans.slot = match_idx[SLOT_W-1:0];
          ans.seen = tbl_seen[match_idx];
        end else begin
          ans.status = ST_NOT_FOUND;
        end
      end
    endcase
    return ans;
  endfunction

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", msg);
  endtask

  task automatic queue_op(input func_e f, input logic [MAC_W-1:0] m,
                          input logic [TIME_W-1:0] t);
    peer_op_t op;
    op.func = f;
    op.mac  = m;
    op.now  = t;
    op_q.push_back(op);
  endtask

  // Waits until every queued operation has been accepted and answered, then lets
  // the block settle for a little longer than one full table scan.
  task automatic drain_and_settle();
    while (op_q.size() != 0 || in_valid || answer_q.size() != 0) @(posedge clk_i);
    repeat (TABLE_ENTRIES + 6) @(posedge clk_i);
  endtask

  // The interval write is only issued while the block is idle, so the local copy
  // can follow it at once when the write transaction completes.
  task automatic write_interval(input logic [INTERVAL_W-1:0] v);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    interval_ms = v;
  endtask

  // Input driver. A new operation is put on the bus only when the bus is empty or
  // the current one was taken at this edge; a stalled operation holds still.
  always @(posedge clk_i) begin : drive_ops
    logic taken;
    int   r;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      burst_left <= 0;
      gap_left   <= 0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        answer_q.push_back(run_peer_op(cur_op));
        n_sent <= n_sent + 1;
      end
      if (!in_valid || taken) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (op_q.size() != 0) begin
          cur_op = op_q.pop_front();
          in_valid <= 1'b1;
          in_func  <= cur_op.func;
          in_mac   <= cur_op.mac;
          in_now   <= cur_op.now;
          if (burst_left <= 1) begin
            // Gaps of up to a few table scans land on every cycle of the work.
            r = $urandom_range(0, 9);
            burst_left <= $urandom_range(1, 24);
            if (r < 4) gap_left <= 0;
            else if (r < 8) gap_left <= $urandom_range(1, 20);
            else gap_left <= $urandom_range(21, 45);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output stall pattern. The mode changes at random intervals: no stall, light
  // random stall, heavy random stall, or a regular on and off beat. From 150 accepted
  // operations on, every 500 more bring a long hold-off that backs the block up into its input.
  always @(posedge clk_i) begin : stall_results
    logic s;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (pat_left == 0) begin
        pat_mode <= $urandom_range(0, 3);
        pat_left <= $urandom_range(20, 200);
      end else begin
        pat_left <= pat_left - 1;
      end
      pat_phase <= pat_phase + 1'b1;
      case (pat_mode)
        0:       s = 1'b0;
        1:       s = ($urandom_range(0, 99) < 35);
        2:       s = ($urandom_range(0, 99) < 80);
        default: s = pat_phase[2];
      endcase
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        s = 1'b1;
      end else if (n_sent >= next_hold_at) begin
        hold_left    <= 250;
        next_hold_at <= next_hold_at + 500;
        s = 1'b1;
      end
      out_stall <= s;
    end
  end

  // Result monitor: every output transaction is matched against the oldest answer.
  always @(posedge clk_i) begin : check_answers
    peer_answer_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (answer_q.size() == 0) begin
        note_failure($sformatf("result with nothing pending: status=%0d hit=%0d slot=%0d seen=%h",
                               status, hit, slot, last_seen));
      end else begin
        want = answer_q.pop_front();
        if (status !== want.status || hit !== want.hit || slot !== want.slot ||
            last_seen !== want.seen) begin
          note_failure($sformatf({"status exp %0d got %0d, hit exp %0d got %0d, ",
                                  "slot exp %0d got %0d, seen exp %h got %h"},
                                 want.status, status, want.hit, hit, want.slot, slot,
                                 want.seen, last_seen));
        end
      end
    end
  end

  initial begin : stimulus
    logic [MAC_W-1:0]      pool [POOL_SIZE];
    logic [INTERVAL_W-1:0] phase_ivl [6];
    logic [TIME_W-1:0]     clock_ms;
    logic [TIME_W-1:0]     span;
    logic [MAC_W-1:0]      m;
    logic [TIME_W-1:0]     t;
    func_e                 f;
    int                    r;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with the interval at its reset value of 60000 ms.
    queue_op(FUNC_FIND,   '0, '0);                 // lookups on an empty table miss
    queue_op(FUNC_REMOVE, '1, '1);
    queue_op(FUNC_PRUNE,  '1, 32'd5);              // prune with nothing to free
    queue_op(FUNC_ADD,    '0, '0);                 // new entry in slot 0
    queue_op(FUNC_ADD,    '1, '1);                 // new entry in slot 1
    queue_op(FUNC_ADD,    '0, 32'd60000);          // refresh of slot 0
    for (int i = 2; i < TABLE_ENTRIES; i++) begin
      queue_op(FUNC_ADD, {16'hA5A5, 32'(i)}, 32'd100);
    end
    queue_op(FUNC_ADD,    48'h5A5A_0000_0077, 32'd200);  // table full, nothing changes
    queue_op(FUNC_FIND,   '1, 32'd300);            // hit with an all-ones heartbeat
    queue_op(FUNC_REMOVE, '0, 32'd300);
    queue_op(FUNC_FIND,   '0, 32'd300);
    // At 60100 the wrapped entry is 60101 ms old and goes; the others sit exactly
    // at the interval and stay. One millisecond later they go too.
    queue_op(FUNC_PRUNE,  48'h1234_5678_9ABC, 32'd60100);
    queue_op(FUNC_PRUNE,  '0, 32'd60101);
    queue_op(FUNC_ADD,    48'h0000_0000_0042, 32'd60102);  // refills the lowest slot
    drain_and_settle();

    // Random phases, each under its own interval, the extremes among them.
    phase_ivl[0] = '0;
    phase_ivl[1] = '1;
    phase_ivl[2] = INTERVAL_W'(1000);
    phase_ivl[3] = INTERVAL_W'($urandom_range(0, 32'h7FFF_FFFF));
    phase_ivl[4] = INTERVAL_W'(60000);
    phase_ivl[5] = INTERVAL_W'(1);
    clock_ms = $urandom;
    for (int p = 0; p < 6; p++) begin
      write_interval(phase_ivl[p]);
      // A pool a little larger than the table keeps it busy, full at times.
      pool[0] = '0;
      pool[1] = '1;
      for (int k = 2; k < POOL_SIZE; k++) pool[k] = {16'($urandom), 32'($urandom)};
      if (p == 2) clock_ms = 32'hFFFF_F000;        // run across the time wrap
      span = {1'b0, phase_ivl[p]} / 8 + 2;
      for (int n = 0; n < 275; n++) begin
        r = $urandom_range(0, 99);
        if (r < 40) f = FUNC_ADD;
        else if (r < 55) f = FUNC_REMOVE;
        else if (r < 65) f = FUNC_PRUNE;
        else f = FUNC_FIND;
        if ($urandom_range(0, 9) == 0) m = {16'($urandom), 32'($urandom)};
        else m = pool[$urandom_range(0, POOL_SIZE - 1)];
        r = $urandom_range(0, 99);
        if (r < 85) begin
          clock_ms = clock_ms + $urandom_range(0, span);
          t = clock_ms;
        end else if (r < 95) begin
          t = $urandom;
        end else begin
          t = clock_ms - $urandom_range(1, 2000);
        end
        queue_op(f, m, t);
      end
      drain_and_settle();
    end

    // Any answer still pending at this point never arrived.
    if (answer_q.size() != 0) begin
      note_failure($sformatf("%0d results never arrived", answer_q.size()));
    end
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog, several times the slowest correct run.
  initial begin
    #1_500_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
